// ===== rtl/lru_cache_set_top_defines.svh =====
// Assertion helpers for the LRU cache set.
`ifndef LRU_CACHE_SET_TOP_DEFINES_SVH
`define LRU_CACHE_SET_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define LCS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lcs: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define LCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lcs: next-cycle check failed");

`endif

// ===== rtl/lcs_pkg.sv =====
`default_nettype none

package lcs_pkg;

    localparam int MAX_WAYS = 8;
    localparam int TAG_BITS = 24;
    localparam int WAY_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CFG_BITS = 4;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [WAY_BITS-1:0] way_t;
    typedef logic [CFG_BITS-1:0] cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lru_cache_set_top.sv =====
// One set of a set-associative cache with true LRU replacement.
// Input channel s_*: one access word per handshake, carrying s_access_tag.
// Result channel m_*: one result word per access: hit flag, way that hit or
//   was filled, and on a miss with all ways in use valid, the evicted tag.
// Config: cfg_wr_en/cfg_wr_data write the ways-in-use count (0 acts as 1,
//   counts above the way total act as all ways); write only while idle.
// Pipeline: an accepted access lands in the input register, then its result
//   word moves to the result register once that register is empty or taken.
//   Throughput: one access per cycle while m_ready stays high; the tag compares,
//   victim pick and rank update sit between those two registers, so each
//   access sees the state left by the previous one.
// Reset: valid bits clear, ranks return to rank == way number, ways-in-use
//   returns to 8. Tags are not cleared; they are only read while valid.
// Stall: while m_ready is low the result register holds; one more access
//   waits in the input register, then s_ready drops until the result drains.
`default_nettype none

`include "lru_cache_set_top_defines.svh"

module lru_cache_set_top
    import lcs_pkg::*;
(
    input  wire  logic aclk,
    input  wire  logic aresetn,

    input  wire  logic cfg_wr_en,
    input  wire  cfg_t cfg_wr_data,

    input  wire  logic s_valid,
    output logic       s_ready,
    input  wire  tag_t s_access_tag,

    output logic       m_valid,
    input  wire  logic m_ready,
    output logic       m_hit,
    output way_t       m_way_index,
    output logic       m_evicted,
    output tag_t       m_evicted_tag
);

    // config
    cfg_t ways_cfg_reg;

    // input stage
    logic in_valid_reg;
    tag_t in_tag_reg;

    // set state
    tag_t tag_reg   [MAX_WAYS];
    way_t rank_reg  [MAX_WAYS];
    way_t rank_next [MAX_WAYS];
    logic [MAX_WAYS-1:0] valid_reg;
    logic [MAX_WAYS-1:0] valid_next;

    // result stage
    logic m_valid_reg;
    logic m_hit_reg;
    way_t m_way_reg;
    logic m_evicted_reg;
    tag_t m_evicted_tag_reg;

    // lookup
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] invalid;
    logic [MAX_WAYS-1:0] oldest;
    logic [MAX_WAYS-1:0] pick;
    logic                hit_c;
    logic                evict_c;
    way_t                sel_way;
    tag_t                ev_tag_c;
    logic                advance;
    logic [MAX_WAYS-1:0] rank_seen;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i]  = (i == 0) || (int'(ways_cfg_reg) > i);
            match[i]   = in_use[i] && valid_reg[i] && (tag_reg[i] == in_tag_reg);
            invalid[i] = in_use[i] && !valid_reg[i];
            // victim: the in-use way no other in-use way outranks
            oldest[i]  = in_use[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (in_use[j] && (rank_reg[j] > rank_reg[i])) begin
                    oldest[i] = 1'b0;
                end
            end
        end

        hit_c   = |match;
        evict_c = !hit_c && !(|invalid);
        if (hit_c) begin
            pick = match;
        end else if (!evict_c) begin
            pick = invalid;
        end else begin
            pick = oldest;
        end

        // lowest-numbered candidate wins
        sel_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (pick[i]) begin
                sel_way = WAY_BITS'(i);
            end
        end

        ev_tag_c = evict_c ? tag_reg[sel_way] : '0;

        // touch: younger ways age by one, selected way becomes MRU
        valid_next = valid_reg;
        valid_next[sel_way] = 1'b1;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (way_t'(i) == sel_way) begin
                rank_next[i] = '0;
            end else if (rank_reg[i] < rank_reg[sel_way]) begin
                rank_next[i] = rank_reg[i] + way_t'(1);
            end else begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_cfg_reg <= CFG_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            valid_reg    <= '0;
            for (int i = 0; i < MAX_WAYS; i++) begin
                rank_reg[i] <= way_t'(i);
            end
        end else begin
            if (cfg_wr_en) begin
                ways_cfg_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                valid_reg   <= valid_next;
                rank_reg    <= rank_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_tag_reg <= s_access_tag;
        end
        if (advance) begin
            m_hit_reg         <= hit_c;
            m_way_reg         <= sel_way;
            m_evicted_reg     <= evict_c;
            m_evicted_tag_reg <= ev_tag_c;
            if (!hit_c) begin
                tag_reg[sel_way] <= in_tag_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_way_index   = m_way_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_tag = m_evicted_tag_reg;

    always_comb begin
        rank_seen = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            rank_seen[rank_reg[i]] = 1'b1;
        end
    end

    `LCS_ASSERT_NOW(a_rank_perm, aclk, aresetn, 1'b1, rank_seen == {MAX_WAYS{1'b1}})
    `LCS_ASSERT_NOW(a_evict_miss, aclk, aresetn, m_valid_reg && m_evicted_reg, !m_hit_reg)
    `LCS_ASSERT_NOW(a_evtag_zero, aclk, aresetn, m_valid_reg && !m_evicted_reg,
        m_evicted_tag_reg == '0)
    `LCS_ASSERT_NEXT(a_sel_mru, aclk, aresetn, advance,
        (rank_reg[m_way_reg] == '0) && valid_reg[m_way_reg])

endmodule

`default_nettype wire

// ===== bench/lru_set_check.sv =====
module lru_set_check
    import lcs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic cfg_wr_en,
    input  wire cfg_t cfg_wr_data,

    input  wire logic s_valid,
    input  wire logic s_ready,
    input  wire tag_t s_access_tag,

    input  wire logic m_valid,
    input  wire logic m_ready,
    input  wire logic m_hit,
    input  wire way_t m_way_index,
    input  wire logic m_evicted,
    input  wire tag_t m_evicted_tag,

    output int        mismatch_count,
    output int        lookups_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic hit;
        way_t way;
        logic evicted;
        tag_t evicted_tag;
    } lookup_t;

    // shadow copy of the set
    tag_t    way_tag  [MAX_WAYS];
    logic    way_live [MAX_WAYS];
    way_t    way_rank [MAX_WAYS];
    cfg_t    ways_cfg;
    lookup_t lookup_q [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // look up one tag, refill on a miss, touch the way; returns the result word
    function automatic lookup_t lookup_and_touch(input tag_t tag);
        lookup_t r;
        int      n;
        int      i;
        int      w;
        int      oldest;
        bit      found;
        way_t    touched_rank;
        r     = '0;
        found = 1'b0;
        w     = 0;
        n     = (ways_cfg == 0) ? 1 : ((ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg));
        // lowest-numbered match wins
        for (i = 0; i < n; i++) begin
            if (!found && way_live[i] && way_tag[i] == tag) begin
                found = 1'b1;
                w     = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
        end else begin
            for (i = 0; i < n; i++) begin
                if (!found && !way_live[i]) begin
                    found = 1'b1;
                    w     = i;
                end
            end
            if (!found) begin
                oldest = 0;
                for (i = 1; i < n; i++) begin
                    if (way_rank[i] > way_rank[oldest]) oldest = i;
                end
                w             = oldest;
                r.evicted     = 1'b1;
                r.evicted_tag = way_tag[w];
            end
            way_tag[w]  = tag;
            way_live[w] = 1'b1;
        end
        // all ways younger than the touched one age, in use or not
        touched_rank = way_rank[w];
        for (i = 0; i < MAX_WAYS; i++) begin
            if (way_rank[i] < touched_rank) way_rank[i]++;
        end
        way_rank[w] = '0;
        r.way       = way_t'(w);
        return r;
    endfunction

    always @(posedge aclk) begin
        lookup_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                way_tag[i]  = '0;
                way_live[i] = 1'b0;
                way_rank[i] = way_t'(i);
            end
            ways_cfg = CFG_RESET;
            lookup_q.delete();
        end else begin
            if (cfg_wr_en) ways_cfg = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (lookup_q.size() == 0) begin
                    report_mismatch("result word with no access pending",
                                    32'(m_way_index), 32'(0));
                end else begin
                    want = lookup_q[0];
                    lookup_q.delete(0);
                    if (m_hit !== want.hit)
                        report_mismatch("hit", 32'(m_hit), 32'(want.hit));
                    if (m_way_index !== want.way)
                        report_mismatch("way_index", 32'(m_way_index), 32'(want.way));
                    if (m_evicted !== want.evicted)
                        report_mismatch("evicted", 32'(m_evicted), 32'(want.evicted));
                    if (m_evicted_tag !== want.evicted_tag)
                        report_mismatch("evicted_tag", 32'(m_evicted_tag),
                                        32'(want.evicted_tag));
                end
            end
            if (s_valid && s_ready) lookup_q = {lookup_q, lookup_and_touch(s_access_tag)};
        end
        lookups_due = lookup_q.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the LRU cache set bench: clock, reset, access stimulus, result-side
// back-pressure and the verdict. All checking lives in lru_set_check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lcs_pkg::*;

    // generous: ample margin for ~860 words at worst-case gap plus stall
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 85;
    // first phases pin the ways-in-use extremes (0 acts as 1, 15 as all ways)
    localparam cfg_t FIXED_WAYS [5] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd2};

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    cfg_t cfg_wr_data;
    logic s_valid;
    logic s_ready;
    tag_t s_access_tag;
    logic m_valid;
    logic m_ready;
    logic m_hit;
    way_t m_way_index;
    logic m_evicted;
    tag_t m_evicted_tag;

    int mismatch_count;
    int lookups_due;
    int cycle_count;
    bit tx_idle;    // sender inserts random gaps
    bit rx_idle;    // receiver inserts random stalls

    lru_cache_set_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_access_tag  (s_access_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_way_index   (m_way_index),
        .m_evicted     (m_evicted),
        .m_evicted_tag (m_evicted_tag)
    );

    lru_set_check check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_access_tag   (s_access_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_way_index    (m_way_index),
        .m_evicted      (m_evicted),
        .m_evicted_tag  (m_evicted_tag),
        .mismatch_count (mismatch_count),
        .lookups_due    (lookups_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycle_count, lookups_due);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: per word, a random stall (when enabled), then take it.
    // m_ready only drops when a nonzero stall is drawn, so back-to-back
    // accepts keep it high without a same-step toggle.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        @(negedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // One access word: optional gap, then hold valid and tag until accepted.
    // Entered and left at a falling edge.
    task automatic send_access(input tag_t tag);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_access_tag <= tag;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drain: stop sending until every result word is back, then let the
    // two-stage pipe settle before anything touches the config register.
    task automatic drain();
        s_valid <= 1'b0;
        while (lookups_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Single-cycle write of ways-in-use; only called when drained.
    task automatic write_ways(input cfg_t ways);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ways;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        tag_t tag_pool [16];
        tag_t tag;
        int   pool_size;
        int   pick;
        cfg_t ways;

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = CFG_RESET;
        s_valid      = 1'b0;
        s_access_tag = '0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        for (int k = 0; k < 16; k++) tag_pool[k] = tag_t'($urandom());

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed ---
        // all 8 ways: tag extremes, a hit, fill every way, then two evictions
        write_ways(4'd8);
        send_access('0);
        send_access('1);
        send_access('0);
        for (int k = 1; k <= 6; k++) send_access(tag_t'(k));
        send_access(tag_t'(7));     // evicts the LRU way (all-ones tag)
        send_access('1);            // evicts the next oldest (tag zero)
        drain();

        // count 0 behaves as a single way: miss evicts way 0, then hits it
        write_ways(4'd0);
        send_access(tag_t'(5));
        send_access(tag_t'(5));
        drain();

        // count 15 behaves as all ways: tag 5 now sits in way 0 and in a
        // higher way left over from before the shrink; lowest match must win
        write_ways(4'd15);
        send_access(tag_t'(5));

        // --- random phases ---
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();    // sender holds off until every result is back
            ways = (phase < 5) ? FIXED_WAYS[phase] : cfg_t'($urandom_range(0, 15));
            write_ways(ways);
            // first phase runs flat out on both sides
            tx_idle = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            // keep half the pool across phases so stale ways get revisited
            // after the count shrinks and grows
            for (int k = 0; k < 16; k++)
                if ($urandom_range(0, 1) == 1) tag_pool[k] = tag_t'($urandom());
            pool_size = $urandom_range(1, 12);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    tag = tag_pool[$urandom_range(0, pool_size - 1)];
                else if (pick < 95)
                    tag = tag_t'($urandom());
                else
                    tag = pick[0] ? '1 : '0;
                if ($urandom_range(0, 149) == 0) drain();
                send_access(tag);
            end
        end

        // --- wrap up ---
        s_valid <= 1'b0;
        while (lookups_due != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
